// ===== rtl/core/plc_pkg.sv =====
`timescale 1ns / 1ps

package plc_pkg;

  localparam int DefCapacity = 16;

  localparam int ActionW   = 2;
  localparam int PositionW = 5;
  localparam int ValueW    = 8;
  localparam int StatusW   = 2;
  localparam int EntriesW  = 5;

  localparam logic [ActionW-1:0] ActAppend   = 2'd0;
  localparam logic [ActionW-1:0] ActInsert   = 2'd1;
  localparam logic [ActionW-1:0] ActDelete   = 2'd2;
  localparam logic [ActionW-1:0] ActTraverse = 2'd3;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StBounds = 2'd1;
  localparam logic [StatusW-1:0] StEmpty  = 2'd2;
  localparam logic [StatusW-1:0] StFull   = 2'd3;

  // what a cell does at the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_WRAP
  } cell_op_e;

endpackage

// ===== rtl/core/plc_cell.sv =====
`timescale 1ns / 1ps

module plc_cell (
  input  logic               clk_i,
  input  plc_pkg::cell_op_e  op_i,
  input  logic [7:0]         value_i,
  input  logic [7:0]         left_i,
  input  logic [7:0]         right_i,
  input  logic [7:0]         wrap_i,
  output logic [7:0]         data_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    case (op_i)
      plc_pkg::CELL_LOAD:  data_d = value_i;
      plc_pkg::CELL_LEFT:  data_d = left_i;
      plc_pkg::CELL_RIGHT: data_d = right_i;
      plc_pkg::CELL_WRAP:  data_d = wrap_i;
      default:             data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/positional_list_store.sv =====
`timescale 1ns / 1ps

// Ordered byte list held in a row of CAPACITY cells. Each input transaction
// (append, insert at position, delete at position, traverse) is accepted
// while no traverse runs and the output is free; append, insert and delete
// shift all cells in parallel and give one registered result transaction.
// Traverse rotates the cell row one place per cycle while the output is not
// stalled and emits cell 0 each time, giving fill results with tlast on the
// final one; the input stays stalled until the last of them is registered.
// An empty traverse gives a single result with has_item low. Failed actions
// leave the list unchanged and report status out of bounds, empty or full.
module positional_list_store #(
  parameter int CAPACITY = plc_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // action[1:0], position[6:2], value[14:7]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // item[7:0], entries[12:8]
  output logic [2:0]  m_axis_tuser,   // has_item[0], status[2:1]
  output logic        m_axis_tlast    // last
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = CntW + plc_pkg::PositionW;

  // input fields
  logic [plc_pkg::ActionW-1:0]   action;
  logic [plc_pkg::PositionW-1:0] position;
  logic [plc_pkg::ValueW-1:0]    value;

  assign action   = s_axis_tdata[1:0];
  assign position = s_axis_tdata[6:2];
  assign value    = s_axis_tdata[14:7];

  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            trav_q, trav_d;

  logic                         out_valid_q, out_valid_d;
  logic [7:0]                   item_q, item_d;
  logic                         has_q, has_d;
  logic [plc_pkg::StatusW-1:0]  status_q, status_d;
  logic                         last_q, last_d;
  logic [plc_pkg::EntriesW-1:0] entries_q, entries_d;

  logic [7:0] cell_data [CAPACITY];

  logic in_acc, out_free, trav_step;
  logic [CmpW-1:0] fill_ext, fill_m1, pos_ext, idx_ext, ins_pos;
  logic do_ins, do_del;
  logic [7:0] gone;
  logic [CntW+plc_pkg::EntriesW-1:0] fill_wide;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !trav_q && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign trav_step     = trav_q && out_free;

  assign fill_ext = CmpW'(fill_q);
  assign fill_m1  = fill_ext - CmpW'(1);
  assign pos_ext  = CmpW'(position);
  assign idx_ext  = CmpW'(idx_q);

  // byte at the delete position, read before the shift
  always_comb begin
    gone = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_ext == CmpW'(i)) begin
        gone = gone | cell_data[i];
      end
    end
  end

  always_comb begin
    fill_d      = fill_q;
    idx_d       = idx_q;
    trav_d      = trav_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    item_d      = item_q;
    has_d       = has_q;
    status_d    = status_q;
    last_d      = last_q;
    fill_wide   = {{plc_pkg::EntriesW{1'b0}}, fill_q};
    entries_d   = entries_q;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    ins_pos     = fill_ext;

    if (in_acc) begin
      out_valid_d = 1'b1;
      item_d      = '0;
      has_d       = 1'b0;
      status_d    = plc_pkg::StOk;
      last_d      = 1'b1;
      case (action)
        plc_pkg::ActAppend: begin
          if (fill_ext == CmpW'(CAPACITY)) begin
            status_d = plc_pkg::StFull;
          end else begin
            do_ins = 1'b1;
            fill_d = fill_q + CntW'(1);
          end
        end
        plc_pkg::ActInsert: begin
          if (pos_ext > fill_ext) begin
            status_d = plc_pkg::StBounds;
          end else if (fill_ext == CmpW'(CAPACITY)) begin
            status_d = plc_pkg::StFull;
          end else begin
            do_ins  = 1'b1;
            ins_pos = pos_ext;
            fill_d  = fill_q + CntW'(1);
          end
        end
        plc_pkg::ActDelete: begin
          if (fill_q == '0) begin
            status_d = plc_pkg::StEmpty;
          end else if (pos_ext >= fill_ext) begin
            status_d = plc_pkg::StBounds;
          end else begin
            do_del = 1'b1;
            item_d = gone;
            has_d  = 1'b1;
            fill_d = fill_q - CntW'(1);
          end
        end
        default: begin
          // traverse: an empty list answers at once
          if (fill_q != '0) begin
            out_valid_d = 1'b0;
            trav_d      = 1'b1;
            idx_d       = '0;
          end
        end
      endcase
      fill_wide = {{plc_pkg::EntriesW{1'b0}}, fill_d};
      entries_d = fill_wide[plc_pkg::EntriesW-1:0];
    end else if (trav_step) begin
      out_valid_d = 1'b1;
      item_d      = cell_data[0];
      has_d       = 1'b1;
      status_d    = plc_pkg::StOk;
      last_d      = (idx_ext == fill_m1);
      entries_d   = fill_wide[plc_pkg::EntriesW-1:0];
      idx_d       = idx_q + CntW'(1);
      if (idx_ext == fill_m1) begin
        trav_d = 1'b0;
      end
    end
  end

  // cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    plc_pkg::cell_op_e op;
    logic [7:0] left, right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end

    always_comb begin
      op = plc_pkg::CELL_HOLD;
      if (do_ins) begin
        if (CmpW'(g) == ins_pos) begin
          op = plc_pkg::CELL_LOAD;
        end else if (CmpW'(g) > ins_pos) begin
          op = plc_pkg::CELL_LEFT;
        end
      end else if (do_del) begin
        if (CmpW'(g) >= pos_ext) begin
          op = plc_pkg::CELL_RIGHT;
        end
      end else if (trav_step) begin
        // rotate the occupied part by one place
        if (CmpW'(g) == fill_m1) begin
          op = plc_pkg::CELL_WRAP;
        end else if (CmpW'(g) < fill_m1) begin
          op = plc_pkg::CELL_RIGHT;
        end
      end
    end

    plc_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .value_i (value),
      .left_i  (left),
      .right_i (right),
      .wrap_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      idx_q       <= '0;
      trav_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      trav_q      <= trav_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    has_q     <= has_d;
    status_q  <= status_d;
    last_q    <= last_d;
    entries_q <= entries_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, entries_q, item_q};
  assign m_axis_tuser  = {status_q, has_q};
  assign m_axis_tlast  = last_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_accept_in_trav : assert property (@(posedge clk_i) disable iff (!rst_ni)
    trav_q |-> !s_axis_tready)
    else $error("input taken during traverse");

  a_fill_only_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> fill_q == $past(fill_q))
    else $error("entry count changed without an input transaction");

  a_trav_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    trav_q |-> (idx_q < fill_q))
    else $error("traverse index past the end of the list");

endmodule
